// ===== sv/ifp_pkg.sv =====
// ----------------------------------------------------------------------------
// ifp_pkg
// Shared types and constants for the imu frame parser with yaw unwrap.
// ----------------------------------------------------------------------------
`default_nettype none

package ifp_pkg;

    localparam int FRAME_LEN = 11;
    localparam int SUM_LEN = 10;
    localparam int SUM_HALF = 5;
    localparam int ID_IDX = 1;
    localparam int RAW_LO_IDX = 6;
    localparam int RAW_HI_IDX = 7;

    localparam logic [7:0] SYNC_BYTE = 8'h55;
    localparam logic [7:0] ID_RATE = 8'h52;
    localparam logic [7:0] ID_ANGLE = 8'h53;

    localparam logic KIND_RATE = 1'b0;
    localparam logic KIND_ANGLE = 1'b1;

    localparam logic signed [16:0] HALF_TURN_POS = 17'sd32768;
    localparam logic signed [16:0] HALF_TURN_NEG = -17'sd32768;
    localparam logic signed [15:0] TURN_MAX = 16'sh7FFF;
    localparam logic signed [15:0] TURN_MIN = 16'sh8000;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
        logic       block_start;
    } in_item_t;

    typedef struct packed {
        logic               frame_kind;
        logic signed [15:0] rate_raw;
        logic signed [15:0] angle_raw;
        logic signed [39:0] yaw_total;
        logic signed [15:0] turn_count;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_RATE,
        OP_ANGLE,
        OP_ZERO
    } op_t;

    // work handed from the frame check to the unwrap stage
    typedef struct packed {
        op_t                op;
        logic signed [15:0] raw;
    } token_t;

endpackage

`default_nettype wire

// ===== sv/ifp_cell.sv =====
// ----------------------------------------------------------------------------
// ifp_cell
// One byte cell of the receive window: holds a byte and its valid flag and
// takes the neighbor's contents, or the new byte at the tail, on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module ifp_cell
    import ifp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       shift_en,
    input  wire logic [7:0] d_byte,
    input  wire logic       d_valid,
    output logic      [7:0] q_byte,
    output logic            q_valid
);

    logic [7:0] byte_reg;
    logic       valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg <= d_byte;
        end
    end

    assign q_byte  = byte_reg;
    assign q_valid = valid_reg;

endmodule

`default_nettype wire

// ===== sv/ifp_unwrap.sv =====
// ----------------------------------------------------------------------------
// ifp_unwrap
// Yaw state: turn counter, last angle, zero offset and held rate, plus the
// result register toward the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ifp_unwrap
    import ifp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      tok_valid,
    input  wire token_t    tok,
    output logic           tok_ready,
    output logic           res_valid,
    input  wire logic      res_stall,
    output out_item_t      res_item
);

    logic signed [15:0] prev_angle_reg, prev_angle_next;
    logic signed [15:0] turns_reg, turns_next;
    logic signed [33:0] offset_reg, offset_next;
    logic signed [15:0] held_rate_reg, held_rate_next;
    logic               res_valid_reg, res_valid_next;
    out_item_t          res_item_reg, res_item_next;

    logic               take;
    logic               load;
    logic               do_zero;
    logic signed [16:0] diff;
    logic signed [33:0] pos_next;

    function automatic logic signed [33:0] unwrap_pos(
        input logic signed [15:0] t,
        input logic signed [15:0] a
    );
        unwrap_pos = {{2{t[15]}}, t, 16'h0000} + {{18{a[15]}}, a};
    endfunction

    assign tok_ready = (tok.op == OP_ZERO) || !res_valid_reg || !res_stall;
    assign take      = tok_valid && tok_ready;
    assign load      = take && (tok.op != OP_ZERO);
    assign do_zero   = take && (tok.op == OP_ZERO);

    assign diff = {prev_angle_reg[15], prev_angle_reg} - {tok.raw[15], tok.raw};

    always_comb
    begin
        prev_angle_next = prev_angle_reg;
        turns_next      = turns_reg;
        offset_next     = offset_reg;
        held_rate_next  = held_rate_reg;

        if (load && tok.op == OP_RATE)
        begin
            held_rate_next = tok.raw;
        end

        if (load && tok.op == OP_ANGLE)
        begin
            prev_angle_next = tok.raw;
            if (diff > HALF_TURN_POS)
            begin
                if (turns_reg != TURN_MAX)
                begin
                    turns_next = turns_reg + 16'sd1;
                end
            end
            else if (diff < HALF_TURN_NEG)
            begin
                if (turns_reg != TURN_MIN)
                begin
                    turns_next = turns_reg - 16'sd1;
                end
            end
        end

        if (do_zero)
        begin
            offset_next = unwrap_pos(turns_reg, prev_angle_reg);
        end
    end

    assign pos_next = unwrap_pos(turns_next, prev_angle_next);

    always_comb
    begin
        res_item_next            = res_item_reg;
        res_item_next.frame_kind = (tok.op == OP_ANGLE) ? KIND_ANGLE : KIND_RATE;
        res_item_next.rate_raw   = held_rate_next;
        res_item_next.angle_raw  = prev_angle_next;
        res_item_next.yaw_total  = {{6{pos_next[33]}}, pos_next}
                                 - {{6{offset_reg[33]}}, offset_reg};
        res_item_next.turn_count = turns_next;

        if (load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_angle_reg <= '0;
            turns_reg      <= '0;
            offset_reg     <= '0;
            held_rate_reg  <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            prev_angle_reg <= prev_angle_next;
            turns_reg      <= turns_next;
            offset_reg     <= offset_next;
            held_rate_reg  <= held_rate_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_item_reg <= res_item_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // the turn counter never moves by more than one per transaction
    a_turn_step: assert property (@(posedge clk) disable iff (!rst_n)
        (turns_reg - $past(turns_reg) == 16'sd0) ||
        (turns_reg - $past(turns_reg) == 16'sd1) ||
        (turns_reg - $past(turns_reg) == -16'sd1))
        else $error("turn counter stepped by more than one");

    // a zero request leaves the angle state alone
    a_zero_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        do_zero |=> ($stable(turns_reg) && $stable(prev_angle_reg)))
        else $error("zero request changed angle state");

    // a new result appears only after a frame token was taken
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(load))
        else $error("result without frame token");

endmodule

`default_nettype wire

// ===== sv/imu_frame_parser_yaw_unwrap.sv =====
// a result goes from the window cells through the check stage register into the result register
// throughput: one transaction per cycle while byte_stall is low; a zero request also takes one slot
// the stall path runs back from the result register through the check stage
// reset: asynchronous, clears the window valid flags, turns, angle, offset and rate
// no clearing pass after reset: the block takes input on the first cycle
// ----------------------------------------------------------------------------
// imu_frame_parser_yaw_unwrap
// Sliding 11-byte window of byte cells, checksum and id check stage, and the
// yaw unwrap stage with its result register.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_frame_parser_yaw_unwrap
    import ifp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      byte_valid,
    output logic           byte_stall,
    input  wire in_item_t  byte_item,
    output logic           res_valid,
    input  wire logic      res_stall,
    output out_item_t      res_item
);

    logic [7:0] cell_byte  [FRAME_LEN];
    logic       cell_valid [FRAME_LEN];
    logic [7:0] link_byte  [FRAME_LEN];
    logic       link_valid [FRAME_LEN];

    logic       accept;
    logic       shift_en;

    logic       s1_valid_reg, s1_valid_next;
    logic       s1_zero_reg, s1_zero_next;
    logic       s2_valid_reg, s2_valid_next;
    token_t     s2_tok_reg, s2_tok_next;

    logic [7:0] sum_lo;
    logic [7:0] sum_hi;
    logic [7:0] sum;
    logic       hit;
    logic       s1_need;
    logic       s1_free;
    logic       s2_free;
    logic       tok_ready;

    assign accept   = byte_valid && !byte_stall;
    assign shift_en = accept && !byte_item.action;

    genvar i;
    generate
        for (i = 0; i < FRAME_LEN; i++)
        begin : g_cell
            if (i == FRAME_LEN - 1)
            begin : g_tail
                assign link_byte[i]  = byte_item.data_byte;
                assign link_valid[i] = 1'b1;
            end
            else
            begin : g_body
                // block start drops every older byte
                assign link_byte[i]  = cell_byte[i + 1];
                assign link_valid[i] = cell_valid[i + 1] && !byte_item.block_start;
            end

            ifp_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .d_byte   (link_byte[i]),
                .d_valid  (link_valid[i]),
                .q_byte   (cell_byte[i]),
                .q_valid  (cell_valid[i])
            );
        end
    endgenerate

    always_comb
    begin
        sum_lo = 8'h00;
        sum_hi = 8'h00;
        for (int k = 0; k < SUM_HALF; k++)
        begin
            sum_lo = sum_lo + cell_byte[k];
            sum_hi = sum_hi + cell_byte[k + SUM_HALF];
        end
        sum = sum_lo + sum_hi;
    end

    assign hit = cell_valid[0]
              && (cell_byte[0] == SYNC_BYTE)
              && (cell_byte[FRAME_LEN - 1] == sum)
              && ((cell_byte[ID_IDX] == ID_RATE) || (cell_byte[ID_IDX] == ID_ANGLE));

    assign s1_need    = s1_valid_reg && (s1_zero_reg || hit);
    assign s2_free    = !s2_valid_reg || tok_ready;
    assign s1_free    = !s1_need || s2_free;
    assign byte_stall = !s1_free;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_zero_next  = s1_zero_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            s1_zero_next  = byte_item.action;
        end
        else if (s1_free)
        begin
            s1_valid_next = 1'b0;
        end

        s2_valid_next = s2_valid_reg;
        s2_tok_next   = s2_tok_reg;
        if (s2_free)
        begin
            s2_valid_next = s1_need;
            if (s1_zero_reg)
            begin
                s2_tok_next.op = OP_ZERO;
            end
            else if (cell_byte[ID_IDX] == ID_RATE)
            begin
                s2_tok_next.op = OP_RATE;
            end
            else
            begin
                s2_tok_next.op = OP_ANGLE;
            end
            s2_tok_next.raw = {cell_byte[RAW_HI_IDX], cell_byte[RAW_LO_IDX]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_zero_reg <= s1_zero_next;
        s2_tok_reg  <= s2_tok_next;
    end

    ifp_unwrap u_unwrap (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (s2_valid_reg),
        .tok       (s2_tok_reg),
        .tok_ready (tok_ready),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule

`default_nettype wire
